[hdl/smvm_pkg.sv]
// Shared definitions for the sparse matrix-vector multiply unit.
// Holds sizes, item kinds, internal operation codes and register addresses.
// No dependencies.
package smvm_pkg;

    // Vector store depth and the largest usable matrix dimension
    localparam int VEC_DEPTH = 1024;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);
    localparam int MAX_DIM   = (VEC_DEPTH < 1024) ? VEC_DEPTH : 1024;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 10;
    localparam int DATA_W  = 32;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ROWS_W  = 11;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_VEC_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONZERO   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ROW_END   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED    = 2'd3;

    // Operation carried down the pipeline
    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_MAC    = 2'd1,
        OP_BADCOL = 2'd2,
        OP_CLOSE  = 2'd3
    } op_t;

    // Register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_ROWS_IN_USE = 3'd0;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd1024;

endpackage

[hdl/smvm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the dense vector store. No dependencies.
module smvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, held while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/sparse_matrix_vector_multiply_unit.sv]
// Sparse matrix times dense vector, CSR order, Q16.16 arithmetic.
// Depends on smvm_pkg and smvm_ram.
//
// The unit takes one item per clock cycle unless in_stall is raised. An item runs
// through three register stages: the vector store read (registered RAM port), the
// 32x32 multiply and the 48-bit saturating accumulate; a row-end passes the stage-1
// and stage-2 registers before the result register captures its row. Back-to-back
// nonzeros are accumulated at full rate while nothing stalls, since the accumulator
// closes its loop within its own stage. The result register holds one finished row;
// while it is full and stalled the whole pipeline holds and in_stall is raised. A
// vector write is visible to a nonzero accepted in the very next cycle. rows_in_use
// should only be written while no transaction is in flight.
module sparse_matrix_vector_multiply_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [smvm_pkg::KIND_W-1:0]      kind,
    input  logic [smvm_pkg::INDEX_W-1:0]     index,
    input  logic signed [smvm_pkg::DATA_W-1:0] value,
    // Result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [smvm_pkg::INDEX_W-1:0]     row_number,
    output logic signed [smvm_pkg::DATA_W-1:0] row_sum,
    output logic                             last_row,
    output logic                             flagged,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [smvm_pkg::PADDR_W-1:0]     paddr,
    input  logic [smvm_pkg::PDATA_W-1:0]     pwdata,
    output logic [smvm_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int AW = smvm_pkg::VEC_AW;
    localparam int DW = smvm_pkg::DATA_W;
    localparam int RW = smvm_pkg::ROWS_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [RW-1:0] rows_reg;
    logic          cfg_write;
    logic [RW-1:0] eff_rows;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == smvm_pkg::ADDR_ROWS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= smvm_pkg::ROWS_RESET;
        end
        else if (cfg_write)
        begin
            rows_reg <= pwdata[RW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == smvm_pkg::ADDR_ROWS_IN_USE)
        begin
            prdata = smvm_pkg::PDATA_W'(rows_reg);
        end
    end

    // Effective dimension: zero acts as one, clipped to the store size
    always_comb
    begin
        if (rows_reg == '0)
        begin
            eff_rows = RW'(1);
        end
        else if (int'(rows_reg) > smvm_pkg::MAX_DIM)
        begin
            eff_rows = RW'(smvm_pkg::MAX_DIM);
        end
        else
        begin
            eff_rows = rows_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: everything moves unless a result is stuck
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic advance;
    logic in_fire;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;
    assign in_fire  = in_valid && advance;

    // ------------------------------------------------------------------
    // Stage 1: decode, vector store access
    // ------------------------------------------------------------------
    smvm_pkg::op_t         s1_op_next;
    logic                  vec_wr_en;
    logic [AW-1:0]         vec_addr;
    logic [DW-1:0]         vec_rd_data;

    logic                  s1_valid_reg;
    smvm_pkg::op_t         s1_op_reg;
    logic signed [DW-1:0]  s1_value_reg;

    assign vec_addr  = AW'(index);
    assign vec_wr_en = in_fire && (kind == smvm_pkg::KIND_VEC_WRITE)
                       && (int'(index) < smvm_pkg::VEC_DEPTH);

    always_comb
    begin
        unique case (kind)
            smvm_pkg::KIND_VEC_WRITE: s1_op_next = smvm_pkg::OP_NOP;
            smvm_pkg::KIND_NONZERO:
            begin
                if (RW'(index) < eff_rows)
                begin
                    s1_op_next = smvm_pkg::OP_MAC;
                end
                else
                begin
                    s1_op_next = smvm_pkg::OP_BADCOL;
                end
            end
            smvm_pkg::KIND_ROW_END:   s1_op_next = smvm_pkg::OP_CLOSE;
            smvm_pkg::KIND_UNUSED:    s1_op_next = smvm_pkg::OP_NOP;
            default:                  s1_op_next = smvm_pkg::OP_NOP;
        endcase
    end

    smvm_ram #(
        .WIDTH (DW),
        .DEPTH (smvm_pkg::VEC_DEPTH)
    ) u_vec_store (
        .clk     (clk),
        .wr_en   (vec_wr_en),
        .wr_addr (vec_addr),
        .wr_data (value),
        .rd_en   (advance),
        .rd_addr (vec_addr),
        .rd_data (vec_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg    <= s1_op_next;
            s1_value_reg <= value;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: 32x32 signed multiply
    // ------------------------------------------------------------------
    logic                                 s2_valid_reg;
    smvm_pkg::op_t                        s2_op_reg;
    logic signed [smvm_pkg::PROD_W-1:0]   s2_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_prod_reg <= s1_value_reg * $signed(vec_rd_data);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: saturating accumulate, row close
    // ------------------------------------------------------------------
    localparam int AC = smvm_pkg::ACC_W;

    logic signed [AC-1:0]  acc_reg;
    logic signed [AC-1:0]  acc_next;
    logic                  flag_reg;
    logic                  flag_next;
    logic [smvm_pkg::INDEX_W-1:0] row_cnt_reg;
    logic [smvm_pkg::INDEX_W-1:0] row_cnt_next;

    logic signed [AC-1:0]  prod_q;
    logic signed [AC:0]    mac_sum;
    logic                  is_last;
    logic signed [DW-1:0]  sum_sat;
    logic                  sum_clamped;

    // Floor shift by 16 is the arithmetic top slice of the product
    assign prod_q  = s2_prod_reg[smvm_pkg::PROD_W-1:16];
    assign mac_sum = {acc_reg[AC-1], acc_reg} + {prod_q[AC-1], prod_q};
    assign is_last = ({1'b0, row_cnt_reg} + RW'(1)) >= eff_rows;

    // Result clamp to 32 bits
    always_comb
    begin
        sum_clamped = !((&acc_reg[AC-1:DW-1]) || !(|acc_reg[AC-1:DW-1]));
        if (!sum_clamped)
        begin
            sum_sat = acc_reg[DW-1:0];
        end
        else if (acc_reg[AC-1])
        begin
            sum_sat = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    always_comb
    begin
        acc_next     = acc_reg;
        flag_next    = flag_reg;
        row_cnt_next = row_cnt_reg;
        if (s2_valid_reg)
        begin
            unique case (s2_op_reg)
                smvm_pkg::OP_MAC:
                begin
                    if (mac_sum[AC] != mac_sum[AC-1])
                    begin
                        acc_next  = mac_sum[AC] ? {1'b1, {(AC-1){1'b0}}}
                                                : {1'b0, {(AC-1){1'b1}}};
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = mac_sum[AC-1:0];
                    end
                end
                smvm_pkg::OP_BADCOL:
                begin
                    flag_next = 1'b1;
                end
                smvm_pkg::OP_CLOSE:
                begin
                    acc_next     = '0;
                    flag_next    = 1'b0;
                    row_cnt_next = is_last ? '0 : row_cnt_reg + 1'b1;
                end
                smvm_pkg::OP_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            flag_reg    <= 1'b0;
            row_cnt_reg <= '0;
        end
        else if (advance)
        begin
            acc_reg     <= acc_next;
            flag_reg    <= flag_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                         close_now;
    logic [smvm_pkg::INDEX_W-1:0] row_number_reg;
    logic signed [DW-1:0]         row_sum_reg;
    logic                         last_row_reg;
    logic                         flagged_reg;

    assign close_now = s2_valid_reg && (s2_op_reg == smvm_pkg::OP_CLOSE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= close_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && close_now)
        begin
            row_number_reg <= row_cnt_reg;
            row_sum_reg    <= sum_sat;
            last_row_reg   <= is_last;
            flagged_reg    <= flag_reg || sum_clamped;
        end
    end

    assign out_valid  = out_valid_reg;
    assign row_number = row_number_reg;
    assign row_sum    = row_sum_reg;
    assign last_row   = last_row_reg;
    assign flagged    = flagged_reg;

endmodule

[dv/sparse_matrix_vector_multiply_unit_tb.sv]
// Self-checking testbench for sparse_matrix_vector_multiply_unit.
// Depends on smvm_pkg and the unit's RTL; a row predictor class holds the expected row results
// while tasks drive the item stream and register port, and a process drives the result stall.
module sparse_matrix_vector_multiply_unit_tb;
    import smvm_pkg::*;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          HOLD_CYCLES   = 250;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          FRAC_BITS     = 16;
    localparam int          REPORT_MAX    = 10;

    localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -(longint'(1) <<< (ACC_W - 1));
    localparam longint SUM_HI = (longint'(1) <<< (DATA_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) <<< (DATA_W - 1));

    typedef struct {
        logic [INDEX_W-1:0]       row_number;
        logic signed [DATA_W-1:0] row_sum;
        logic                     last_row;
        logic                     flagged;
    } row_result_t;

    // Tracks vector store, row accumulator and row counter; queues finished rows
    class smvm_row_predictor;
        logic [ROWS_W-1:0]        rows = ROWS_RESET;
        logic signed [DATA_W-1:0] vec [VEC_DEPTH];
        longint                   acc;
        bit [INDEX_W-1:0]         row_ctr;
        bit                       row_flag;
        row_result_t              rows_due [$];
        int                       fail_cnt;

        function void set_rows(logic [ROWS_W-1:0] v);
            rows = v;
        endfunction

        // Effective dimension: zero acts as one, clipped to the store size
        function int dim();
            int n;
            n = int'(rows);
            if (n == 0)
                n = 1;
            if (n > MAX_DIM)
                n = MAX_DIM;
            return n;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        function int failures();
            return fail_cnt;
        endfunction

        // Apply one accepted input transaction
        function void absorb_item(logic [KIND_W-1:0] k, logic [INDEX_W-1:0] idx,
                                  logic signed [DATA_W-1:0] v);
            row_result_t r;
            longint      s;
            int          n;
            n = dim();
            case (k)
                KIND_VEC_WRITE:
                begin
                    if (int'(idx) < VEC_DEPTH)
                        vec[idx] = v;
                end
                KIND_NONZERO:
                begin
                    if (int'(idx) >= n)
                        row_flag = 1'b1;
                    else
                    begin
                        // exact Q32.32 product, floor to Q32.16, saturating add
                        s = acc + ((longint'(v) * longint'(vec[idx])) >>> FRAC_BITS);
                        if (s > ACC_HI)
                        begin
                            s = ACC_HI;
                            row_flag = 1'b1;
                        end
                        if (s < ACC_LO)
                        begin
                            s = ACC_LO;
                            row_flag = 1'b1;
                        end
                        acc = s;
                    end
                end
                KIND_ROW_END:
                begin
                    s = acc;
                    r.flagged = row_flag;
                    if (s > SUM_HI)
                    begin
                        s = SUM_HI;
                        r.flagged = 1'b1;
                    end
                    if (s < SUM_LO)
                    begin
                        s = SUM_LO;
                        r.flagged = 1'b1;
                    end
                    r.row_number = row_ctr;
                    r.row_sum    = s[DATA_W-1:0];
                    r.last_row   = (int'(row_ctr) + 1) >= n;
                    rows_due.insert(rows_due.size(), r);
                    row_ctr  = r.last_row ? '0 : row_ctr + 1'b1;
                    acc      = 0;
                    row_flag = 1'b0;
                end
                default:
                begin
                    // unused kind: ignored
                end
            endcase
        endfunction

        // Compare one accepted result transaction with the oldest expected row
        function void compare_row(logic [INDEX_W-1:0] rn, logic signed [DATA_W-1:0] rs,
                                  logic lr, logic fl);
            row_result_t e;
            if (rows_due.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX)
                    $display("unexpected row result: row %0d sum %0d last %0b flag %0b",
                             rn, rs, lr, fl);
                return;
            end
            e = rows_due.pop_front();
            if (rn !== e.row_number || rs !== e.row_sum || lr !== e.last_row
                || fl !== e.flagged)
            begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX)
                    $display({"row mismatch: exp row %0d sum %0d last %0b flag %0b, ",
                              "got row %0d sum %0d last %0b flag %0b"},
                             e.row_number, e.row_sum, e.last_row, e.flagged,
                             rn, rs, lr, fl);
            end
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic [KIND_W-1:0]          kind      = KIND_VEC_WRITE;
    logic [INDEX_W-1:0]         index     = '0;
    logic signed [DATA_W-1:0]   value     = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [INDEX_W-1:0]         row_number;
    logic signed [DATA_W-1:0]   row_sum;
    logic                       last_row;
    logic                       flagged;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [PADDR_W-1:0]         paddr     = ADDR_ROWS_IN_USE;
    logic [PDATA_W-1:0]         pwdata    = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    smvm_row_predictor tracker = new();

    bit          written [VEC_DEPTH];
    int          items_sent    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req      = 1'b0;
    bit          hold_done     = 1'b0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;

    sparse_matrix_vector_multiply_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_number (row_number),
        .row_sum    (row_sum),
        .last_row   (last_row),
        .flagged    (flagged),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result stall: random, plus one long hold-off that this process counts itself
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.compare_row(row_number, row_sum, last_row, flagged);
    end

    // Offer one input transaction and hold it until accepted
    task automatic push_item(input logic [KIND_W-1:0] k, input int idx,
                             input logic signed [DATA_W-1:0] v);
        if (k == KIND_VEC_WRITE)
            written[idx] = 1'b1;
        if (k != KIND_UNUSED)
            items_sent++;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        index    <= INDEX_W'(idx);
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        tracker.absorb_item(k, INDEX_W'(idx), v);
    endtask

    // Wait for every expected row, then for the pipeline to empty
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup then access cycle
    task automatic write_rows(input logic [ROWS_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ROWS_IN_USE;
        pwdata  <= PDATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.set_rows(v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            2, 3: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
            default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    // One row: nonzeros mixed with stray writes, bad columns and unused kinds, then close
    task automatic gen_row();
        int n;
        int nnz;
        int pick;
        int c;
        n = tracker.dim();
        nnz = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
        repeat (nnz)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                push_item(KIND_UNUSED, $urandom_range(0, 1023), rand_value());
            else if (pick < 14)
                push_item(KIND_VEC_WRITE,
                          $urandom_range(0, 1) ? $urandom_range(0, n - 1)
                                               : $urandom_range(0, 1023),
                          rand_value());
            else if (pick < 20 && n < MAX_DIM)
                push_item(KIND_NONZERO, $urandom_range(n, 1023), rand_value());
            else
            begin
                c = $urandom_range(0, n - 1);
                // never read a vector entry that has not been written
                if (!written[c])
                    push_item(KIND_VEC_WRITE, c, rand_value());
                push_item(KIND_NONZERO, c, rand_value());
            end
        end
        push_item(KIND_ROW_END, $urandom_range(0, 1023), rand_value());
    endtask

    // Random phase: segments of rows, each under a fresh dimension
    task automatic run_phase(input int tx_pct, input int rx_pct, input int target,
                             input bit with_hold);
        int               stop;
        int               seg_end;
        bit               first;
        logic [ROWS_W-1:0] dim_sel;
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        stop  = items_sent + target;
        first = 1'b1;
        while (items_sent < stop)
        begin
            settle();
            case ($urandom_range(0, 9))
                0: dim_sel = 11'd1;
                1: dim_sel = 11'd0;
                2: dim_sel = 11'd2047;
                3: dim_sel = 11'd1024;
                4: dim_sel = 11'd2;
                9: dim_sel = ROWS_W'($urandom_range(41, 1024));
                default: dim_sel = ROWS_W'($urandom_range(3, 40));
            endcase
            write_rows(dim_sel);
            if (with_hold && first)
                hold_req = 1'b1;
            first   = 1'b0;
            seg_end = items_sent + $urandom_range(40, 120);
            while (items_sent < seg_end && items_sent < stop)
                gen_row();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full dimension, extreme vector entries
        write_rows(11'd1024);
        push_item(KIND_VEC_WRITE, 0,    32'h7FFF_FFFF);
        push_item(KIND_VEC_WRITE, 1023, 32'h8000_0000);
        push_item(KIND_VEC_WRITE, 1,    32'h0001_0000);
        push_item(KIND_VEC_WRITE, 2,    32'hFFFF_0000);
        // plain row with a product that floors towards minus infinity
        push_item(KIND_NONZERO, 1, 32'h0002_0000);
        push_item(KIND_NONZERO, 0, -32'sd3);
        push_item(KIND_ROW_END, 0, 0);
        // empty row
        push_item(KIND_ROW_END, 1023, 32'hFFFF_FFFF);
        // accumulator saturation
        push_item(KIND_NONZERO, 1023, 32'h8000_0000);
        push_item(KIND_NONZERO, 1023, 32'h8000_0000);
        push_item(KIND_NONZERO, 1023, 32'h8000_0000);
        push_item(KIND_ROW_END, 0, 0);
        // unused kind
        push_item(KIND_UNUSED, 1023, 32'hFFFF_FFFF);
        // result clamps high, then low
        push_item(KIND_NONZERO, 0, 32'h0002_0000);
        push_item(KIND_ROW_END, 0, 0);
        push_item(KIND_NONZERO, 1023, 32'h7FFF_FFFF);
        push_item(KIND_ROW_END, 0, 0);

        // Column out of range, then dimension lowered so that the current row is the last
        settle();
        write_rows(11'd8);
        push_item(KIND_NONZERO, 9, 32'h0001_0000);
        push_item(KIND_ROW_END, 0, 0);
        push_item(KIND_ROW_END, 0, 0);
        settle();
        write_rows(11'd3);
        push_item(KIND_ROW_END, 0, 0);
        // zero dimension acts as one
        settle();
        write_rows(11'd0);
        push_item(KIND_ROW_END, 0, 0);
        push_item(KIND_ROW_END, 0, 0);
        settle();
        write_rows(11'd2047);

        run_phase(11, 87, 590, 1'b0);
        run_phase(87, 11, 590, 1'b0);
        run_phase(0, 0, 590, 1'b1);
        settle();

        if (tracker.failures() == 0 && tracker.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sparse_matrix_vector_multiply_unit.f]
hdl/smvm_pkg.sv
hdl/smvm_ram.sv
hdl/sparse_matrix_vector_multiply_unit.sv
dv/sparse_matrix_vector_multiply_unit_tb.sv
